FILE: hw/rtl/bcpu_pkg.sv
// ---------------------------------------------------------------------------
// Byte CPU execute unit package
// Shared types and constants for the execute unit, its register file,
// its stack memory and its iterative divider.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package bcpu_pkg;

   // Default sizes of the register file and the stack.
   localparam int NUM_REGS_DEF    = 16;
   localparam int STACK_DEPTH_DEF = 16;

   // Number of restoring-division steps for an 8-bit operand.
   localparam int DIV_STEPS = 8;

   // Instruction opcodes.
   typedef enum logic [3:0] {
      OP_NOP  = 4'd0,
      OP_MOV  = 4'd1,
      OP_LDI  = 4'd2,
      OP_ADD  = 4'd3,
      OP_SUB  = 4'd4,
      OP_MUL  = 4'd5,
      OP_DIV  = 4'd6,
      OP_MOD  = 4'd7,
      OP_JMP  = 4'd8,
      OP_JPZ  = 4'd9,
      OP_JPV  = 4'd10,
      OP_PUSH = 4'd11,
      OP_POP  = 4'd12
   } op_type;

   // Error codes reported with each result.
   typedef enum logic [2:0] {
      ERR_OK    = 3'd0,
      ERR_REG   = 3'd1,
      ERR_ADDR  = 3'd2,
      ERR_FULL  = 3'd3,
      ERR_EMPTY = 3'd4,
      ERR_DIV0  = 3'd5
   } err_type;

   // Sequencer states of the execute unit.
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_DIVIDE
   } state_type;

   // Result of the iterative divider.
   typedef struct packed {
      logic [7:0] quotient;
      logic [7:0] remainder;
      logic       overflow;
   } div_result_type;

endpackage

FILE: hw/rtl/bcpu_regfile.sv
// ---------------------------------------------------------------------------
// Byte CPU register file
// Synchronous memory with two registered read ports and one write port.
// Per-entry valid bits make never-written registers read as zero.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module bcpu_regfile #(
   parameter int NUM_REGS = 16,
   parameter int RAW      = $clog2(NUM_REGS)
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic [RAW-1:0]          rd_addr_a,
   input  logic [RAW-1:0]          rd_addr_b,
   output logic signed [7:0]       rd_data_a,
   output logic signed [7:0]       rd_data_b,
   input  logic                    wr_en,
   input  logic [RAW-1:0]          wr_addr,
   input  logic signed [7:0]       wr_data
);
   import bcpu_pkg::*;

   logic signed [7:0]  mem [NUM_REGS];
   logic [NUM_REGS-1:0] valid_ff;
   logic signed [7:0]  data_a_ff;
   logic signed [7:0]  data_b_ff;
   logic               valid_a_ff;
   logic               valid_b_ff;

   // Memory array: one write, two registered reads.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      data_a_ff <= mem[rd_addr_a];
      data_b_ff <= mem[rd_addr_b];
   end

   // Valid bits are cleared by reset and set on the first write.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff   <= '0;
         valid_a_ff <= 1'b0;
         valid_b_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         valid_a_ff <= valid_ff[rd_addr_a];
         valid_b_ff <= valid_ff[rd_addr_b];
      end
   end

   // An entry that was never written reads as zero.
   assign rd_data_a = valid_a_ff ? data_a_ff : 8'sd0;
   assign rd_data_b = valid_b_ff ? data_b_ff : 8'sd0;

endmodule

FILE: hw/rtl/bcpu_stack.sv
// ---------------------------------------------------------------------------
// Byte CPU stack memory
// Synchronous memory holding the push-down stack entries; one write port
// and one registered read port.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module bcpu_stack #(
   parameter int STACK_DEPTH = 16,
   parameter int SAW         = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [SAW-1:0]       wr_addr,
   input  logic signed [7:0]    wr_data,
   input  logic [SAW-1:0]       rd_addr,
   output logic signed [7:0]    rd_data
);
   import bcpu_pkg::*;

   logic signed [7:0] mem [STACK_DEPTH];
   logic signed [7:0] rd_data_ff;

   // Write and registered read.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hw/rtl/bcpu_divider.sv
// ---------------------------------------------------------------------------
// Byte CPU divider
// Signed 8-bit truncating divider: restoring division on the magnitudes,
// one quotient bit per cycle, then sign correction of both results.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module bcpu_divider (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic signed [7:0]        dividend,
   input  logic signed [7:0]        divisor,
   output bcpu_pkg::div_result_type result,
   output logic                     done
);
   import bcpu_pkg::*;

   logic       busy_ff, busy_in;
   logic       done_ff, done_in;
   logic [3:0] count_ff, count_in;
   logic [7:0] quo_ff, quo_in;
   logic [7:0] rem_ff, rem_in;
   logic [7:0] div_ff, div_in;
   logic       qneg_ff, qneg_in;
   logic       rneg_ff, rneg_in;
   logic [8:0] trial;
   logic [8:0] diff;
   logic       fits;
   logic [8:0] qmag;
   logic [8:0] qfull;

   // One restoring step: shift in the next dividend bit and try a subtract.
   always_comb begin
      trial = {rem_ff, quo_ff[7]};
      diff  = trial - {1'b0, div_ff};
      fits  = (trial >= {1'b0, div_ff});
   end

   // Next-state logic of the iteration.
   always_comb begin
      busy_in  = busy_ff;
      done_in  = done_ff;
      count_in = count_ff;
      quo_in   = quo_ff;
      rem_in   = rem_ff;
      div_in   = div_ff;
      qneg_in  = qneg_ff;
      rneg_in  = rneg_ff;
      if (start) begin
         busy_in  = 1'b1;
         done_in  = 1'b0;
         count_in = 4'(DIV_STEPS);
         quo_in   = dividend[7] ? 8'(-dividend) : dividend;
         div_in   = divisor[7] ? 8'(-divisor) : divisor;
         rem_in   = '0;
         qneg_in  = dividend[7] ^ divisor[7];
         rneg_in  = dividend[7];
      end else if (busy_ff) begin
         quo_in   = {quo_ff[6:0], fits};
         rem_in   = fits ? diff[7:0] : trial[7:0];
         count_in = count_ff - 4'd1;
         if (count_ff == 4'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
      quo_ff  <= quo_in;
      rem_ff  <= rem_in;
      div_ff  <= div_in;
      qneg_ff <= qneg_in;
      rneg_ff <= rneg_in;
   end

   // Sign correction; only -128 / -1 gives a positive 128 quotient.
   always_comb begin
      qmag             = {1'b0, quo_ff};
      qfull            = qneg_ff ? 9'(-qmag) : qmag;
      result.quotient  = qfull[7:0];
      result.remainder = rneg_ff ? 8'(-rem_ff) : rem_ff;
      result.overflow  = !qneg_ff && quo_ff[7];
   end

   assign done = done_ff;

   // A new division is only started while the unit is not iterating.
   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      start |-> !busy_ff)
      else $error("divider started while busy");

   // Completion follows the last iteration step.
   a_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      $rose(done_ff) |-> $past(busy_ff) && !busy_ff)
      else $error("divider done without iterating");

endmodule

FILE: hw/rtl/byte_cpu_execute_unit_core.sv
// ---------------------------------------------------------------------------
// Byte CPU execute unit
// Executes one decoded instruction per transaction against a register
// file and stack held in synchronous memories, with flags, PC and stack
// pointer in registers.
// ---------------------------------------------------------------------------
// Sequence: an accepted request enters the execute state, which commits the
//   result for all operations except div and mod; those start the divider and
//   commit from the divide state after its 8 iterations. A commit waits while
//   the output register holds an untaken result; the result is then held until
//   the consumer takes it. One transaction is handled at a time, and the unit
//   returns to idle after each commit before it accepts another request.
// Reset: synchronous; clears flags, PC, stack pointer and register valid bits.
`timescale 1ns / 1ps

module byte_cpu_execute_unit_core #(
   parameter int NUM_REGS    = bcpu_pkg::NUM_REGS_DEF,
   parameter int STACK_DEPTH = bcpu_pkg::STACK_DEPTH_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [3:0]        req_op,
   input  logic [7:0]        req_dest_reg,
   input  logic [7:0]        req_src_reg,
   input  logic signed [7:0] req_immediate,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [2:0]        rsp_error,
   output logic signed [7:0] rsp_written_value,
   output logic              rsp_zero_flag,
   output logic              rsp_negative_flag,
   output logic              rsp_overflow_flag,
   output logic [6:0]        rsp_program_counter,
   output logic              rsp_jump_taken
);
   import bcpu_pkg::*;

   localparam int RAW = $clog2(NUM_REGS);
   localparam int SAW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam int SPW = $clog2(STACK_DEPTH + 1);

   // Sequencer and architectural registers.
   state_type         state_ff, state_in;
   logic [3:0]        op_ff;
   logic [7:0]        dest_ff;
   logic [7:0]        src_ff;
   logic signed [7:0] imm_ff;
   logic              zf_ff, zf_in;
   logic              nf_ff, nf_in;
   logic              vf_ff, vf_in;
   logic [6:0]        pc_ff, pc_in;
   logic [SPW-1:0]    sp_ff, sp_in;

   // Output register.
   logic              rsp_valid_ff, rsp_valid_in;
   err_type           rsp_error_ff, err_in;
   logic signed [7:0] rsp_wval_ff, wval_in;
   logic              rsp_zf_ff;
   logic              rsp_nf_ff;
   logic              rsp_vf_ff;
   logic [6:0]        rsp_pc_ff;
   logic              rsp_taken_ff, taken_in;

   // Memory and divider connections.
   logic [RAW-1:0]    rd_addr_a;
   logic [RAW-1:0]    rd_addr_b;
   logic signed [7:0] sv;
   logic signed [7:0] dv;
   logic              rf_we;
   logic signed [7:0] rf_wdata;
   logic              st_we;
   logic [SPW-1:0]    sp_dec;
   logic signed [7:0] st_rdata;
   logic              div_start;
   logic              div_done;
   div_result_type    div_res;

   // Execute datapath signals.
   logic              accept;
   logic              out_free;
   logic              commit;
   logic              s_ok;
   logic              d_ok;
   logic signed [15:0] full;
   logic signed [7:0] res8;
   logic              ovf;

   assign accept   = req_valid && !req_stall;
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE);

   // Address the register file read ports from the request while idle, else from the latch.
   assign rd_addr_a = (state_ff == ST_IDLE) ? req_src_reg[RAW-1:0]  : src_ff[RAW-1:0];
   assign rd_addr_b = (state_ff == ST_IDLE) ? req_dest_reg[RAW-1:0] : dest_ff[RAW-1:0];
   assign sp_dec    = sp_ff - SPW'(1);

   bcpu_regfile #(
      .NUM_REGS (NUM_REGS),
      .RAW      (RAW)
   ) u_regfile (
      .clock     (clock),
      .reset     (reset),
      .rd_addr_a (rd_addr_a),
      .rd_addr_b (rd_addr_b),
      .rd_data_a (sv),
      .rd_data_b (dv),
      .wr_en     (rf_we),
      .wr_addr   (dest_ff[RAW-1:0]),
      .wr_data   (rf_wdata)
   );

   bcpu_stack #(
      .STACK_DEPTH (STACK_DEPTH),
      .SAW         (SAW)
   ) u_stack (
      .clock   (clock),
      .wr_en   (st_we),
      .wr_addr (sp_ff[SAW-1:0]),
      .wr_data (dv),
      .rd_addr (sp_dec[SAW-1:0]),
      .rd_data (st_rdata)
   );

   bcpu_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (sv),
      .divisor  (dv),
      .result   (div_res),
      .done     (div_done)
   );

   // Operand range checks and the combinational arithmetic.
   always_comb begin
      s_ok = ({1'b0, src_ff} < 9'(NUM_REGS));
      d_ok = ({1'b0, dest_ff} < 9'(NUM_REGS));
      case (op_type'(op_ff))
         OP_ADD:  full = 16'(dv) + 16'(sv);
         OP_SUB:  full = 16'(dv) - 16'(sv);
         OP_MUL:  full = dv * sv;
         default: full = '0;
      endcase
      res8 = full[7:0];
      ovf  = (full != 16'(res8));
   end

   // Sequencer: execute, optional divide, then commit into the output register.
   always_comb begin
      state_in  = state_ff;
      zf_in     = zf_ff;
      nf_in     = nf_ff;
      vf_in     = vf_ff;
      pc_in     = pc_ff;
      sp_in     = sp_ff;
      err_in    = ERR_OK;
      wval_in   = 8'sd0;
      taken_in  = 1'b0;
      rf_we     = 1'b0;
      rf_wdata  = 8'sd0;
      st_we     = 1'b0;
      div_start = 1'b0;
      commit    = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            commit = out_free;
            case (op_type'(op_ff))
               OP_MOV: begin
                  if (!s_ok || !d_ok) begin
                     err_in = ERR_REG;
                  end else begin
                     rf_we    = 1'b1;
                     rf_wdata = sv;
                     wval_in  = sv;
                  end
               end
               OP_LDI: begin
                  if (!d_ok) begin
                     err_in = ERR_REG;
                  end else begin
                     rf_we    = 1'b1;
                     rf_wdata = imm_ff;
                     wval_in  = imm_ff;
                  end
               end
               OP_ADD, OP_SUB, OP_MUL: begin
                  zf_in = 1'b0;
                  nf_in = 1'b0;
                  vf_in = 1'b0;
                  if (!s_ok || !d_ok) begin
                     err_in = ERR_REG;
                  end else begin
                     rf_we    = 1'b1;
                     rf_wdata = res8;
                     wval_in  = res8;
                     zf_in    = (res8 == 8'sd0);
                     nf_in    = res8[7];
                     vf_in    = ovf;
                  end
               end
               OP_DIV, OP_MOD: begin
                  zf_in = 1'b0;
                  nf_in = 1'b0;
                  vf_in = 1'b0;
                  if (!s_ok || !d_ok) begin
                     err_in = ERR_REG;
                  end else if (dv == 8'sd0) begin
                     err_in = ERR_DIV0;
                  end else begin
                     // Hand over to the divider; commit happens later.
                     commit    = 1'b0;
                     div_start = 1'b1;
                     state_in  = ST_DIVIDE;
                  end
               end
               OP_JMP, OP_JPZ, OP_JPV: begin
                  if ((op_type'(op_ff) == OP_JMP) ||
                      (op_type'(op_ff) == OP_JPZ && zf_ff) ||
                      (op_type'(op_ff) == OP_JPV && vf_ff)) begin
                     if (imm_ff[7]) begin
                        err_in = ERR_ADDR;
                     end else begin
                        pc_in    = imm_ff[6:0];
                        zf_in    = 1'b0;
                        nf_in    = 1'b0;
                        vf_in    = 1'b0;
                        taken_in = 1'b1;
                     end
                  end
               end
               OP_PUSH: begin
                  if (!d_ok) begin
                     err_in = ERR_REG;
                  end else if (sp_ff >= SPW'(STACK_DEPTH)) begin
                     err_in = ERR_FULL;
                  end else begin
                     st_we = 1'b1;
                     sp_in = sp_ff + SPW'(1);
                  end
               end
               OP_POP: begin
                  if (sp_ff == '0) begin
                     err_in = ERR_EMPTY;
                  end else begin
                     sp_in = sp_dec;
                     if (!d_ok) begin
                        err_in = ERR_REG;
                     end else begin
                        rf_we    = 1'b1;
                        rf_wdata = st_rdata;
                        wval_in  = st_rdata;
                     end
                  end
               end
               default: begin
               end
            endcase
            if (commit && !div_start) begin
               state_in = ST_IDLE;
            end
         end
         ST_DIVIDE: begin
            commit = div_done && out_free;
            wval_in = (op_type'(op_ff) == OP_MOD) ? div_res.remainder : div_res.quotient;
            zf_in   = (wval_in == 8'sd0);
            nf_in   = wval_in[7];
            vf_in   = (op_type'(op_ff) == OP_DIV) && div_res.overflow;
            rf_wdata = wval_in;
            rf_we    = commit;
            if (commit) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      // Architectural state only moves when the transaction commits.
      if (!commit) begin
         zf_in = zf_ff;
         nf_in = nf_ff;
         vf_in = vf_ff;
         pc_in = pc_ff;
         sp_in = sp_ff;
         rf_we = 1'b0;
         st_we = 1'b0;
      end
      rsp_valid_in = commit ? 1'b1 : (rsp_valid_ff && rsp_stall);
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         zf_ff        <= 1'b0;
         nf_ff        <= 1'b0;
         vf_ff        <= 1'b0;
         pc_ff        <= '0;
         sp_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         zf_ff        <= zf_in;
         nf_ff        <= nf_in;
         vf_ff        <= vf_in;
         pc_ff        <= pc_in;
         sp_ff        <= sp_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Instruction latch and result payload.
   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff   <= req_op;
         dest_ff <= req_dest_reg;
         src_ff  <= req_src_reg;
         imm_ff  <= req_immediate;
      end
      if (commit) begin
         rsp_error_ff <= err_in;
         rsp_wval_ff  <= wval_in;
         rsp_zf_ff    <= zf_in;
         rsp_nf_ff    <= nf_in;
         rsp_vf_ff    <= vf_in;
         rsp_pc_ff    <= pc_in;
         rsp_taken_ff <= taken_in;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_error           = rsp_error_ff;
   assign rsp_written_value   = rsp_wval_ff;
   assign rsp_zero_flag       = rsp_zf_ff;
   assign rsp_negative_flag   = rsp_nf_ff;
   assign rsp_overflow_flag   = rsp_vf_ff;
   assign rsp_program_counter = rsp_pc_ff;
   assign rsp_jump_taken      = rsp_taken_ff;

   // An accepted transaction always starts with the execute cycle.
   a_accept_exec: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == ST_EXEC)
      else $error("accepted transaction did not enter execute");

   // The stack pointer never passes the stack depth.
   a_sp_range: assert property (@(posedge clock) disable iff (reset)
      sp_ff <= SPW'(STACK_DEPTH))
      else $error("stack pointer out of range");

   // A commit presents a result and frees the unit for the next transaction.
   a_commit_result: assert property (@(posedge clock) disable iff (reset)
      commit |=> rsp_valid_ff && state_ff == ST_IDLE)
      else $error("commit did not present a result");

   // A taken jump never reports an error.
   a_jump_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_taken_ff |-> rsp_error_ff == ERR_OK)
      else $error("taken jump with error code");

endmodule

FILE: tb/byte_cpu_execute_unit_core_test.sv
// ---------------------------------------------------------------------------
// Byte CPU execute unit testbench
// Drives decoded instructions into the execute unit, predicts every result
// from a local model of the register file, flags, PC and stack, and checks
// each result transaction field by field. Directed cases cover the value
// extremes, every opcode and the error paths. A pressure phase fills the
// stack while the result side is held off, and a long random phase follows.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module byte_cpu_execute_unit_core_test;
   import bcpu_pkg::*;

   localparam int NUM_REGS    = NUM_REGS_DEF;
   localparam int STACK_DEPTH = STACK_DEPTH_DEF;
   localparam int RANDOM_ITEMS = 1400;

   // Receiver stall modes.
   localparam int STALL_NONE     = 0;
   localparam int STALL_LIGHT    = 1;
   localparam int STALL_HEAVY    = 2;
   localparam int STALL_PERIODIC = 3;

   // One expected or observed result transaction.
   typedef struct packed {
      err_type           err;
      logic signed [7:0] written;
      logic              zero;
      logic              negative;
      logic              overflow;
      logic [6:0]        pc;
      logic              jump;
   } exec_result_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   logic [3:0]        req_op = OP_NOP;
   logic [7:0]        req_dest_reg = '0;
   logic [7:0]        req_src_reg = '0;
   logic signed [7:0] req_immediate = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   logic [2:0]        rsp_error;
   logic signed [7:0] rsp_written_value;
   logic              rsp_zero_flag;
   logic              rsp_negative_flag;
   logic              rsp_overflow_flag;
   logic [6:0]        rsp_program_counter;
   logic              rsp_jump_taken;

   // Machine state as the predictor sees it.
   logic signed [7:0] machine_regs [NUM_REGS];
   logic signed [7:0] machine_stack [STACK_DEPTH];
   int                machine_sp;
   logic              flag_z, flag_n, flag_v;
   logic [6:0]        machine_pc;

   exec_result_type expected_results [$];
   int           mismatch_count = 0;
   int           executed_count = 0;
   int           burst_left = 0;
   int           hold_request = 0;

   byte_cpu_execute_unit_core i_dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_op              (req_op),
      .req_dest_reg        (req_dest_reg),
      .req_src_reg         (req_src_reg),
      .req_immediate       (req_immediate),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_error           (rsp_error),
      .rsp_written_value   (rsp_written_value),
      .rsp_zero_flag       (rsp_zero_flag),
      .rsp_negative_flag   (rsp_negative_flag),
      .rsp_overflow_flag   (rsp_overflow_flag),
      .rsp_program_counter (rsp_program_counter),
      .rsp_jump_taken      (rsp_jump_taken)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // Carry out one instruction on the local machine state and return the
   // result the unit must report for it.
   function automatic exec_result_type execute_instruction(input logic [3:0] op,
                                                           input logic [7:0] d,
                                                           input logic [7:0] s,
                                                           input logic signed [7:0] imm);
      exec_result_type   r;
      int                sv, dv, full;
      logic              bad_regs, jump_wanted;
      logic signed [7:0] popped;
      r = '0;
      r.err = ERR_OK;
      jump_wanted = 1'b0;
      bad_regs = (s >= NUM_REGS) || (d >= NUM_REGS);
      case (op)
         OP_MOV: begin
            if (bad_regs) begin
               r.err = ERR_REG;
            end else begin
               machine_regs[d[3:0]] = machine_regs[s[3:0]];
               r.written = machine_regs[d[3:0]];
            end
         end
         OP_LDI: begin
            if (d >= NUM_REGS) begin
               r.err = ERR_REG;
            end else begin
               machine_regs[d[3:0]] = imm;
               r.written = imm;
            end
         end
         OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD: begin
            // Flags clear first, even when the operation then fails.
            flag_z = 1'b0;
            flag_n = 1'b0;
            flag_v = 1'b0;
            if (bad_regs) begin
               r.err = ERR_REG;
            end else begin
               sv = machine_regs[s[3:0]];
               dv = machine_regs[d[3:0]];
               if ((op == OP_DIV || op == OP_MOD) && dv == 0) begin
                  r.err = ERR_DIV0;
               end else begin
                  case (op)
                     OP_ADD:  full = dv + sv;
                     OP_SUB:  full = dv - sv;
                     OP_MUL:  full = dv * sv;
                     OP_DIV:  full = sv / dv;
                     default: full = sv % dv;
                  endcase
                  machine_regs[d[3:0]] = full[7:0];
                  r.written = full[7:0];
                  flag_z = (full[7:0] == 8'd0);
                  flag_n = full[7];
                  flag_v = (op != OP_MOD) && (full < -128 || full > 127);
               end
            end
         end
         OP_JMP: jump_wanted = 1'b1;
         OP_JPZ: jump_wanted = flag_z;
         OP_JPV: jump_wanted = flag_v;
         OP_PUSH: begin
            if (d >= NUM_REGS) begin
               r.err = ERR_REG;
            end else if (machine_sp >= STACK_DEPTH) begin
               r.err = ERR_FULL;
            end else begin
               machine_stack[machine_sp] = machine_regs[d[3:0]];
               machine_sp++;
            end
         end
         OP_POP: begin
            // A pop to a bad register still removes the entry.
            if (machine_sp == 0) begin
               r.err = ERR_EMPTY;
            end else begin
               machine_sp--;
               popped = machine_stack[machine_sp];
               if (d >= NUM_REGS) begin
                  r.err = ERR_REG;
               end else begin
                  machine_regs[d[3:0]] = popped;
                  r.written = popped;
               end
            end
         end
         default: ;
      endcase

      // A taken jump to a negative target is an address fault.
      if (jump_wanted) begin
         if (imm[7]) begin
            r.err = ERR_ADDR;
         end else begin
            machine_pc = imm[6:0];
            flag_z = 1'b0;
            flag_n = 1'b0;
            flag_v = 1'b0;
            r.jump = 1'b1;
         end
      end
      r.zero = flag_z;
      r.negative = flag_n;
      r.overflow = flag_v;
      r.pc = machine_pc;
      return r;
   endfunction

   function automatic logic [7:0] pick_reg();
      if ($urandom_range(0, 9) == 0) begin
         return 8'($urandom_range(NUM_REGS, 255));
      end
      return 8'($urandom_range(0, NUM_REGS - 1));
   endfunction

   // Operand values lean toward the corners of the signed range.
   function automatic logic signed [7:0] pick_value();
      case ($urandom_range(0, 11))
         0:       return -8'sd128;
         1:       return 8'sd127;
         2:       return 8'sd0;
         3:       return -8'sd1;
         4:       return 8'sd1;
         default: return 8'($urandom);
      endcase
   endfunction

   function automatic void note_failure(input string what);
      mismatch_count++;
      if (mismatch_count <= 10) begin
         $display("%t: %s", $realtime, what);
      end
   endfunction

   // Offer one instruction, wait for the transaction, record its expected
   // result, then maybe pause the sender between bursts.
   task automatic issue_instruction(input logic [3:0] op, input logic [7:0] d,
                                    input logic [7:0] s, input logic signed [7:0] imm);
      int gap;
      req_valid <= 1'b1;
      req_op <= op;
      req_dest_reg <= d;
      req_src_reg <= s;
      req_immediate <= imm;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      expected_results.push_back(execute_instruction(op, d, s, imm));
      if (op >= OP_MOV && op <= OP_POP) executed_count++;
      burst_left--;
      if (burst_left <= 0) begin
         burst_left = $urandom_range(1, 20);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   // Result checker: each result transaction against the oldest expectation.
   initial begin
      exec_result_type got, want;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) begin
            got.err = err_type'(rsp_error);
            got.written = rsp_written_value;
            got.zero = rsp_zero_flag;
            got.negative = rsp_negative_flag;
            got.overflow = rsp_overflow_flag;
            got.pc = rsp_program_counter;
            got.jump = rsp_jump_taken;
            if (expected_results.size() == 0) begin
               note_failure($sformatf("unexpected result err=%0d value=%0d",
                                      rsp_error, rsp_written_value));
            end else begin
               want = expected_results.pop_front();
               if (got.err !== want.err || got.written !== want.written ||
                   got.zero !== want.zero || got.negative !== want.negative ||
                   got.overflow !== want.overflow || got.pc !== want.pc ||
                   got.jump !== want.jump) begin
                  note_failure({
                     $sformatf("mismatch: expected err=%0d val=%0d z=%b n=%b v=%b pc=%0d j=%b",
                               want.err, want.written, want.zero, want.negative,
                               want.overflow, want.pc, want.jump),
                     $sformatf(", got err=%0d val=%0d z=%b n=%b v=%b pc=%0d j=%b",
                               got.err, got.written, got.zero, got.negative,
                               got.overflow, got.pc, got.jump)});
               end
            end
         end
      end
   end

   // Receiver: stalls on a changing pattern, or holds off for a long stretch
   // when the pressure test asks for it.
   initial begin
      int mode, mode_left, hold_left, period;
      mode = STALL_NONE;
      mode_left = 0;
      hold_left = 0;
      period = 3;
      forever begin
         @(posedge clock);
         if (hold_request != 0) begin
            hold_left = hold_request;
            hold_request = 0;
         end
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else begin
            if (mode_left == 0) begin
               mode = $urandom_range(STALL_NONE, STALL_PERIODIC);
               mode_left = $urandom_range(32, 256);
               period = $urandom_range(2, 5);
            end
            mode_left--;
            case (mode)
               STALL_NONE:  rsp_stall <= 1'b0;
               STALL_LIGHT: rsp_stall <= ($urandom_range(0, 9) < 3);
               STALL_HEAVY: rsp_stall <= ($urandom_range(0, 9) < 7);
               default:     rsp_stall <= (mode_left % period == 0);
            endcase
         end
      end
   end

   // Loads and moves at the value extremes, bad register indexes, nops.
   task automatic test_registers_and_moves();
      issue_instruction(OP_LDI, 8'd0, 8'd0, 8'sd127);
      issue_instruction(OP_LDI, 8'd15, 8'd0, -8'sd128);
      issue_instruction(OP_LDI, 8'd2, 8'd0, -8'sd1);
      issue_instruction(OP_MOV, 8'd3, 8'd0, 8'sd0);
      issue_instruction(OP_MOV, 8'd3, 8'd16, 8'sd0);
      issue_instruction(OP_LDI, 8'd255, 8'd0, 8'sd5);
      issue_instruction(OP_NOP, 8'd255, 8'd255, -8'sd1);
      issue_instruction(4'd13, 8'd1, 8'd1, 8'sd1);
      issue_instruction(4'd15, 8'd1, 8'd1, 8'sd1);
   endtask

   // Signed overflow on add, subtract and multiply, the wrapping divide, divide by zero.
   task automatic test_arithmetic_cases();
      issue_instruction(OP_ADD, 8'd3, 8'd0, 8'sd0);
      issue_instruction(OP_SUB, 8'd15, 8'd0, 8'sd0);
      issue_instruction(OP_LDI, 8'd4, 8'd0, -8'sd128);
      issue_instruction(OP_MUL, 8'd2, 8'd4, 8'sd0);
      issue_instruction(OP_LDI, 8'd6, 8'd0, -8'sd1);
      issue_instruction(OP_DIV, 8'd6, 8'd4, 8'sd0);
      issue_instruction(OP_DIV, 8'd1, 8'd0, 8'sd0);
      issue_instruction(OP_MOD, 8'd1, 8'd0, 8'sd0);
      issue_instruction(OP_LDI, 8'd8, 8'd0, 8'sd3);
      issue_instruction(OP_MOD, 8'd8, 8'd4, 8'sd0);
      issue_instruction(OP_ADD, 8'd10, 8'd200, 8'sd0);
   endtask

   // Taken and untaken conditional jumps, negative targets.
   task automatic test_jumps();
      issue_instruction(OP_JPZ, 8'd0, 8'd0, -8'sd5);
      issue_instruction(OP_SUB, 8'd9, 8'd9, 8'sd0);
      issue_instruction(OP_JPZ, 8'd0, 8'd0, 8'sd127);
      issue_instruction(OP_JMP, 8'd0, 8'd0, -8'sd1);
      issue_instruction(OP_LDI, 8'd11, 8'd0, 8'sd127);
      issue_instruction(OP_ADD, 8'd11, 8'd0, 8'sd0);
      issue_instruction(OP_JPV, 8'd0, 8'd0, -8'sd2);
      issue_instruction(OP_JPV, 8'd0, 8'd0, 8'sd64);
      issue_instruction(OP_JPV, 8'd0, 8'd0, -8'sd128);
      issue_instruction(OP_JMP, 8'd0, 8'd0, 8'sd0);
   endtask

   // Hold off the result side while the stack is filled past full and then
   // drained past empty, so the unit backs up into its input.
   task automatic test_stack_under_backpressure();
      hold_request = 400;
      for (int i = 0; i <= STACK_DEPTH; i++) begin
         issue_instruction(OP_PUSH, 8'(i % NUM_REGS), 8'd0, 8'sd0);
      end
      issue_instruction(OP_PUSH, 8'd128, 8'd0, 8'sd0);
      issue_instruction(OP_POP, 8'd77, 8'd0, 8'sd0);
      for (int i = 1; i <= STACK_DEPTH; i++) begin
         issue_instruction(OP_POP, 8'(i % NUM_REGS), 8'd0, 8'sd0);
      end
   endtask

   // Random programs: mostly operand loads followed by arithmetic and
   // conditional jumps, stack bursts, and some fully random noise.
   task automatic test_random_programs();
      logic [7:0]  a, b;
      logic [3:0]  op;
      int          n;
      while (executed_count < RANDOM_ITEMS) begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: begin
               a = pick_reg();
               b = pick_reg();
               issue_instruction(OP_LDI, a, 8'd0, pick_value());
               issue_instruction(OP_LDI, b, 8'd0, pick_value());
               op = 4'($urandom_range(OP_ADD, OP_MOD));
               if ($urandom_range(0, 1)) begin
                  issue_instruction(op, a, b, pick_value());
               end else begin
                  issue_instruction(op, b, a, pick_value());
               end
               if ($urandom_range(0, 1)) begin
                  op = $urandom_range(0, 1) ? OP_JPZ : OP_JPV;
                  issue_instruction(op, pick_reg(), pick_reg(), 8'($urandom));
               end
               if ($urandom_range(0, 3) == 0) begin
                  issue_instruction(OP_MOV, pick_reg(), pick_reg(), 8'($urandom));
               end
            end
            5, 6: begin
               n = $urandom_range(1, STACK_DEPTH + 2);
               repeat (n) issue_instruction(OP_PUSH, pick_reg(), pick_reg(), 8'($urandom));
               n = $urandom_range(1, STACK_DEPTH + 2);
               repeat (n) issue_instruction(OP_POP, pick_reg(), pick_reg(), 8'($urandom));
            end
            7: issue_instruction(OP_JMP, pick_reg(), pick_reg(), 8'($urandom));
            default: begin
               op = ($urandom_range(0, 7) == 0) ? 4'($urandom_range(0, 15))
                                                : 4'($urandom_range(OP_NOP, OP_POP));
               issue_instruction(op, 8'($urandom), 8'($urandom), 8'($urandom));
            end
         endcase
      end
   endtask

   // Main sequence.
   initial begin
      for (int i = 0; i < NUM_REGS; i++) machine_regs[i] = '0;
      for (int i = 0; i < STACK_DEPTH; i++) machine_stack[i] = '0;
      machine_sp = 0;
      machine_pc = '0;
      flag_z = 1'b0;
      flag_n = 1'b0;
      flag_v = 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      test_registers_and_moves();
      test_arithmetic_cases();
      test_jumps();
      test_stack_under_backpressure();
      executed_count = 0;
      test_random_programs();
      req_valid <= 1'b0;

      // Drain, then give the unit time to show any stray result.
      while (expected_results.size() != 0) @(posedge clock);
      repeat (30) @(posedge clock);
      if (expected_results.size() != 0) note_failure("results missing at end of run");

      if (mismatch_count == 0) begin
         $display("** byte_cpu_execute_unit_core: PASSED **");
      end else begin
         $display("** byte_cpu_execute_unit_core: FAILED **");
      end
      $finish;
   end

   // Watchdog for a hung handshake.
   initial begin
      #2_000_000;
      $display("** byte_cpu_execute_unit_core: FAILED **");
      $finish;
   end

endmodule
